// ----- sv/rlh_pkg.sv -----
// Package for the RGB and luma histogram block: constants, kind codes and
// the command struct passed from the controller to the datapath.
// No dependencies.
package rlh_pkg;

    // Fixed field widths
    localparam int LEVEL_W  = 8;    // one colour byte, also the counter index
    localparam int BIN_W    = 9;    // requested bin
    localparam int KIND_W   = 2;
    localparam int FIELD_W  = 32;   // count fields on the result beat
    localparam int LEVELS   = 1 << LEVEL_W;

    // Default counter width, handed to the top level parameter
    localparam int COUNT_WIDTH_DEF = 32;

    // Histogram bins seen from outside; each counter covers BIN_COUNT/256 bins
    localparam int BIN_COUNT = 512;

    // bin -> counter index as (bin * BIN_RECIP) >> BIN_SHIFT, exact for bin < 512
    localparam int BIN_SHIFT  = 20;
    localparam int BIN_RECIP  = ((1 << BIN_SHIFT) * LEVELS + BIN_COUNT - 1) / BIN_COUNT;
    localparam int BIN_RCP_W  = BIN_SHIFT + 1;
    localparam int BIN_PROD_W = BIN_W + BIN_RCP_W;

    // BT.709 luma in Q16, rounded half up; coefficients sum to 2^16
    localparam int COEF_W = 16;
    localparam int PROD_W = COEF_W + LEVEL_W;
    localparam logic [COEF_W-1:0] LUMA_CR   = 16'd13933;
    localparam logic [COEF_W-1:0] LUMA_CG   = 16'd46871;
    localparam logic [COEF_W-1:0] LUMA_CB   = 16'd4732;
    localparam logic [PROD_W-1:0] LUMA_HALF = 24'd32768;

    typedef enum logic [KIND_W-1:0] {
        KIND_PIXEL = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef struct packed {
        logic               capture;   // latch the input payload
        logic               pix_mul;   // register luma products
        logic               pix_rd;    // read counters for a pixel
        logic               pix_wr;    // write back incremented counters
        logic               bin_rd;    // read counters for a bin request
        logic               out_load;  // load the result register
        logic               clr_wr;    // write zero during a clearing sweep
        logic [LEVEL_W-1:0] clr_addr;
    } dp_cmd_t;

endpackage

// ----- sv/rlh_in_if.sv -----
// Input channel of the histogram block: valid/ready plus the item payload.
// Depends on rlh_pkg for field widths.
interface rlh_in_if;
    logic                       valid;
    logic                       ready;
    logic [rlh_pkg::KIND_W-1:0]  kind;
    logic [rlh_pkg::LEVEL_W-1:0] red;
    logic [rlh_pkg::LEVEL_W-1:0] green;
    logic [rlh_pkg::LEVEL_W-1:0] blue;
    logic                       in_region;
    logic [rlh_pkg::BIN_W-1:0]   bin;

    modport source (output valid, kind, red, green, blue, in_region, bin, input ready);
    modport sink   (input valid, kind, red, green, blue, in_region, bin, output ready);
endinterface

// ----- sv/rlh_out_if.sv -----
// Result channel of the histogram block: valid/ready plus four counts.
// Depends on rlh_pkg for field widths.
interface rlh_out_if;
    logic                        valid;
    logic                        ready;
    logic [rlh_pkg::FIELD_W-1:0] red_count;
    logic [rlh_pkg::FIELD_W-1:0] green_count;
    logic [rlh_pkg::FIELD_W-1:0] blue_count;
    logic [rlh_pkg::FIELD_W-1:0] luma_count;

    modport source (output valid, red_count, green_count, blue_count, luma_count,
                    input ready);
    modport sink   (input valid, red_count, green_count, blue_count, luma_count,
                    output ready);
endinterface

// ----- sv/rgb_luma_histogram_core.sv -----
// Pixel pass: accept, multiply, counter read, write back; next beat after write back.
// Bin read: accept, counter read, result register load (waits while it is full).
// Clear: sweep over all 256 counter RAM addresses, one address per cycle.
// Each item is bounded by the single read/write port pair of the counter RAMs.
// Reset (rst_n low, async) starts the same sweep; req.ready stays low until it ends.
//
// Top level of the RGB and BT.709 luma histogram block.
// Depends on rlh_pkg, rlh_in_if, rlh_out_if, rlh_ctrl, rlh_datapath.
module rgb_luma_histogram_core #(
    parameter int COUNT_WIDTH = rlh_pkg::COUNT_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rlh_in_if.sink     req,
    rlh_out_if.source  rsp
);

    // Controller and datapath meet only on this command bundle
    rlh_pkg::dp_cmd_t cmd;

    // The controller owns both handshakes. A pixel outside the crop box and
    // an unused kind code are taken and dropped without leaving the idle state.
    rlh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_kind   (req.kind),
        .in_region (req.in_region),
        .in_ready  (req.ready),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .cmd       (cmd)
    );

    // Counters are one per 8-bit value per channel; a bin request is mapped
    // to its counter and out-of-range bins read back as zero. The result
    // register lets the next beat be taken while a result waits.
    rlh_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .red         (req.red),
        .green       (req.green),
        .blue        (req.blue),
        .bin         (req.bin),
        .red_count   (rsp.red_count),
        .green_count (rsp.green_count),
        .blue_count  (rsp.blue_count),
        .luma_count  (rsp.luma_count)
    );

endmodule

// ----- sv/rlh_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rlh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/rlh_ctrl.sv -----
// Controller of the histogram block: sequences pixel updates, bin reads and
// clearing sweeps, and owns both handshakes. Depends on rlh_pkg.
module rlh_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [rlh_pkg::KIND_W-1:0]    in_kind,
    input  logic                          in_region,
    output logic                          in_ready,
    input  logic                          out_ready,
    output logic                          out_valid,
    output rlh_pkg::dp_cmd_t              cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIX_MUL,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_BIN_RD,
        ST_BIN_OUT
    } state_t;

    state_t                       state_reg, state_next;
    logic [rlh_pkg::LEVEL_W-1:0]  clr_addr_reg, clr_addr_next;
    logic                         out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.clr_addr  = clr_addr_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr    = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (&clr_addr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (in_kind)
                        rlh_pkg::KIND_PIXEL:
                        begin
                            if (in_region)
                            begin
                                state_next = ST_PIX_MUL;
                            end
                        end
                        rlh_pkg::KIND_READ:
                        begin
                            state_next = ST_BIN_RD;
                        end
                        rlh_pkg::KIND_CLEAR:
                        begin
                            clr_addr_next = '0;
                            state_next    = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PIX_MUL:
            begin
                cmd.pix_mul = 1'b1;
                state_next  = ST_PIX_RD;
            end
            ST_PIX_RD:
            begin
                cmd.pix_rd = 1'b1;
                state_next = ST_PIX_WR;
            end
            ST_PIX_WR:
            begin
                cmd.pix_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_BIN_RD:
            begin
                cmd.bin_rd = 1'b1;
                state_next = ST_BIN_OUT;
            end
            ST_BIN_OUT:
            begin
                // wait for the result register to be free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- sv/rlh_datapath.sv -----
// Datapath of the histogram block: luma arithmetic, bin mapping, the four
// counter RAMs and the result register. Depends on rlh_pkg and rlh_ram.
module rlh_datapath #(
    parameter int COUNT_WIDTH = rlh_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          clk,
    input  rlh_pkg::dp_cmd_t              cmd,
    input  logic [rlh_pkg::LEVEL_W-1:0]   red,
    input  logic [rlh_pkg::LEVEL_W-1:0]   green,
    input  logic [rlh_pkg::LEVEL_W-1:0]   blue,
    input  logic [rlh_pkg::BIN_W-1:0]     bin,
    output logic [rlh_pkg::FIELD_W-1:0]   red_count,
    output logic [rlh_pkg::FIELD_W-1:0]   green_count,
    output logic [rlh_pkg::FIELD_W-1:0]   blue_count,
    output logic [rlh_pkg::FIELD_W-1:0]   luma_count
);

    localparam int CHANS   = 4;  // red, green, blue, luma
    localparam int LEVEL_W = rlh_pkg::LEVEL_W;
    localparam int FIELD_W = rlh_pkg::FIELD_W;
    localparam int PROD_W  = rlh_pkg::PROD_W;

    logic [LEVEL_W-1:0]         red_reg, green_reg, blue_reg, luma_reg, luma_next;
    logic [rlh_pkg::BIN_W-1:0]  bin_reg;
    logic [PROD_W-1:0]          prod_r_reg, prod_g_reg, prod_b_reg;
    logic [PROD_W-1:0]          luma_sum;
    logic                       oor_reg;
    logic [rlh_pkg::BIN_PROD_W-1:0] bin_prod;
    logic [LEVEL_W-1:0]         bin_idx;

    logic [LEVEL_W-1:0]     pix_raddr [CHANS];
    logic [LEVEL_W-1:0]     pix_waddr [CHANS];
    logic [COUNT_WIDTH-1:0] rdata     [CHANS];
    logic [FIELD_W-1:0]     field     [CHANS];
    logic [FIELD_W-1:0]     count_reg [CHANS];

    // Sum of the three products never exceeds 255.5 * 2^16, so the top
    // byte is the rounded luma without clamping.
    assign luma_sum  = prod_r_reg + prod_g_reg + prod_b_reg + rlh_pkg::LUMA_HALF;
    assign luma_next = luma_sum[PROD_W-1 -: LEVEL_W];

    assign bin_prod = rlh_pkg::BIN_PROD_W'(bin_reg)
                    * rlh_pkg::BIN_PROD_W'(rlh_pkg::BIN_RECIP);
    assign bin_idx  = bin_prod[rlh_pkg::BIN_SHIFT +: LEVEL_W];

    assign pix_raddr[0] = red_reg;
    assign pix_raddr[1] = green_reg;
    assign pix_raddr[2] = blue_reg;
    assign pix_raddr[3] = luma_next;
    assign pix_waddr[0] = red_reg;
    assign pix_waddr[1] = green_reg;
    assign pix_waddr[2] = blue_reg;
    assign pix_waddr[3] = luma_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
            bin_reg   <= bin;
        end
        if (cmd.pix_mul)
        begin
            prod_r_reg <= rlh_pkg::LUMA_CR * red_reg;
            prod_g_reg <= rlh_pkg::LUMA_CG * green_reg;
            prod_b_reg <= rlh_pkg::LUMA_CB * blue_reg;
        end
        if (cmd.pix_rd)
        begin
            luma_reg <= luma_next;
        end
        if (cmd.bin_rd)
        begin
            oor_reg <= (bin_reg >= rlh_pkg::BIN_W'(rlh_pkg::BIN_COUNT - 1))
                    && (bin_reg != rlh_pkg::BIN_W'(rlh_pkg::BIN_COUNT - 1));
        end
        if (cmd.out_load)
        begin
            for (int c = 0; c < CHANS; c++)
            begin
                count_reg[c] <= oor_reg ? '0 : field[c];
            end
        end
    end

    for (genvar c = 0; c < CHANS; c++)
    begin : g_chan
        logic [LEVEL_W-1:0]     raddr, waddr;
        logic [COUNT_WIDTH-1:0] wdata;

        assign raddr = cmd.bin_rd ? bin_idx : pix_raddr[c];
        assign waddr = cmd.clr_wr ? cmd.clr_addr : pix_waddr[c];
        // saturating increment; zero during a clear
        assign wdata = cmd.clr_wr ? '0
                     : ((&rdata[c]) ? rdata[c] : rdata[c] + 1'b1);

        rlh_ram #(
            .WIDTH (COUNT_WIDTH),
            .DEPTH (rlh_pkg::LEVELS)
        ) u_ram (
            .clk   (clk),
            .we    (cmd.clr_wr | cmd.pix_wr),
            .waddr (waddr),
            .wdata (wdata),
            .re    (cmd.pix_rd | cmd.bin_rd),
            .raddr (raddr),
            .rdata (rdata[c])
        );

        if (COUNT_WIDTH > FIELD_W)
        begin : g_sat
            assign field[c] = (|rdata[c][COUNT_WIDTH-1:FIELD_W]) ? '1
                            : rdata[c][FIELD_W-1:0];
        end
        else if (COUNT_WIDTH == FIELD_W)
        begin : g_same
            assign field[c] = rdata[c];
        end
        else
        begin : g_ext
            assign field[c] = {{(FIELD_W - COUNT_WIDTH){1'b0}}, rdata[c]};
        end
    end

    assign red_count   = count_reg[0];
    assign green_count = count_reg[1];
    assign blue_count  = count_reg[2];
    assign luma_count  = count_reg[3];

endmodule

// ----- sv/rlh_checker.sv -----
// Port-level checks for the histogram block, bound into the top level.
// Depends on rlh_pkg and rgb_luma_histogram_core.
module rlh_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic [rlh_pkg::KIND_W-1:0]   in_kind,
    input logic                         in_region,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [rlh_pkg::FIELD_W-1:0]  red_count,
    input logic [rlh_pkg::FIELD_W-1:0]  green_count,
    input logic [rlh_pkg::FIELD_W-1:0]  blue_count,
    input logic [rlh_pkg::FIELD_W-1:0]  luma_count
);

    // result beat held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(red_count) && $stable(green_count)
            && $stable(blue_count) && $stable(luma_count))
        else $error("result payload changed while stalled");

    // a counted pixel keeps the block busy for its read-modify-write
    a_pix_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_region && (in_kind == rlh_pkg::KIND_PIXEL)
            |=> !in_ready ##1 !in_ready)
        else $error("pixel beat overlapped with previous update");

    // a clear blocks input at the start of its sweep
    a_clr_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_kind == rlh_pkg::KIND_CLEAR) |=> !in_ready)
        else $error("beat accepted during clearing sweep");

    // a new result only follows a busy cycle of a bin read
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a bin read");

endmodule

bind rgb_luma_histogram_core rlh_checker u_rlh_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .in_kind     (req.kind),
    .in_region   (req.in_region),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .red_count   (rsp.red_count),
    .green_count (rsp.green_count),
    .blue_count  (rsp.blue_count),
    .luma_count  (rsp.luma_count)
);
